[hw/rtl/rbp_pkg.sv]
`default_nettype none

package rbp_pkg;

    localparam int PIXEL_BITS      = 8;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT      = 1024;
    localparam int DIM_BITS        = 11;
    localparam int DRAIN_BITS      = 12;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 11;
    localparam int WIDTH_RESET     = 640;
    localparam int HEIGHT_RESET    = 480;
    localparam int CMDQ_DEPTH      = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       row_end;
        logic       frame_end;
        logic       last_of_run;
    } t_out_item;

    // one classified item: pixel plus its edge roles
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  left;
        logic                  right;
        logic                  last_out;
    } t_cmd;

    typedef struct packed {
        logic afull;
        logic full;
    } t_qstat;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input int unsigned max_v);
        logic [DIM_BITS-1:0] r;
        if (v == '0) begin
            r = DIM_BITS'(1);
        end else if (32'(v) > max_v) begin
            r = DIM_BITS'(max_v);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rbp_ram.sv]
`default_nettype none

module rbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]      i_wdata,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [WIDTH-1:0]      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/rbp_front.sv]
`default_nettype none

module rbp_front #(
    parameter int MAX_WIDTH = rbp_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    input  wire rbp_pkg::t_in_item                   i_item,
    input  wire logic                                i_hold,
    input  wire logic                                i_cfg_we,
    input  wire logic [rbp_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [rbp_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output logic                                     o_cmd_push,
    output rbp_pkg::t_cmd                            o_cmd
);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DB = rbp_pkg::DIM_BITS;
    localparam int CB = rbp_pkg::DRAIN_BITS;
    localparam int PB = rbp_pkg::PIXEL_BITS;

    localparam logic [DB-1:0] W_RST =
        rbp_pkg::clamp_dim(DB'(rbp_pkg::WIDTH_RESET), MAX_WIDTH);
    localparam logic [DB-1:0] H_RST =
        rbp_pkg::clamp_dim(DB'(rbp_pkg::HEIGHT_RESET), rbp_pkg::MAX_HEIGHT);

    logic [DB-1:0] r_w, r_wm1, r_h, r_col, r_row;
    logic [CB-1:0] r_w2, r_drain;
    logic [DB-1:0] n_w, n_wm1, n_h, n_col, n_row;
    logic [CB-1:0] n_w2, n_drain;

    logic          r_s1_valid;
    logic          r_s1_use_ram;
    logic [PB-1:0] r_s1_pix;
    logic          r_s1_left, r_s1_right, r_s1_last;

    logic          accept, pix_ok, drain_ok, second;
    logic [DB-1:0] dcol, col_sel, cfg_dim_w, cfg_dim_h;
    logic [CB-1:0] drain_inc;
    logic [PB-1:0] pix, ram_q;

    assign accept   = i_push && !i_hold;
    assign pix      = i_item.pixel_in[PB-1:0];
    assign pix_ok   = (i_item.mode == rbp_pkg::MODE_PIXEL) && (r_row < r_h);
    assign drain_ok = (i_item.mode == rbp_pkg::MODE_DRAIN) && (r_row >= r_h);

    // drain ticks walk the stored row twice: image row, then bottom pad
    assign second    = r_drain >= {1'b0, r_w};
    assign dcol      = second ? DB'(r_drain - {1'b0, r_w}) : r_drain[DB-1:0];
    assign col_sel   = (i_item.mode == rbp_pkg::MODE_DRAIN) ? dcol : r_col;
    assign drain_inc = r_drain + CB'(1);

    assign cfg_dim_w = rbp_pkg::clamp_dim(i_cfg_data, MAX_WIDTH);
    assign cfg_dim_h = rbp_pkg::clamp_dim(i_cfg_data, rbp_pkg::MAX_HEIGHT);

    rbp_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept && pix_ok),
        .i_waddr (col_sel[AW-1:0]),
        .i_wdata (pix),
        .i_re    (accept),
        .i_raddr (col_sel[AW-1:0]),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_w     = r_w;
        n_wm1   = r_wm1;
        n_w2    = r_w2;
        n_h     = r_h;
        n_col   = r_col;
        n_row   = r_row;
        n_drain = r_drain;
        if (i_cfg_we) begin
            // any register write restarts the frame
            n_col   = '0;
            n_row   = '0;
            n_drain = '0;
            if (i_cfg_index == rbp_pkg::REG_IMAGE_WIDTH) begin
                n_w   = cfg_dim_w;
                n_wm1 = cfg_dim_w - DB'(1);
                n_w2  = {cfg_dim_w, 1'b0};
            end else if (i_cfg_index == rbp_pkg::REG_IMAGE_HEIGHT) begin
                n_h = cfg_dim_h;
            end
        end else if (accept && pix_ok) begin
            if (r_col == r_wm1) begin
                n_col = '0;
                n_row = r_row + DB'(1);
            end else begin
                n_col = r_col + DB'(1);
            end
        end else if (accept && drain_ok) begin
            if (drain_inc >= r_w2) begin
                n_drain = '0;
                n_row   = '0;
                n_col   = '0;
            end else begin
                n_drain = drain_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w        <= W_RST;
            r_wm1      <= W_RST - DB'(1);
            r_w2       <= {W_RST, 1'b0};
            r_h        <= H_RST;
            r_col      <= '0;
            r_row      <= '0;
            r_drain    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_w        <= n_w;
            r_wm1      <= n_wm1;
            r_w2       <= n_w2;
            r_h        <= n_h;
            r_col      <= n_col;
            r_row      <= n_row;
            r_drain    <= n_drain;
            r_s1_valid <= accept && (pix_ok || drain_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_use_ram <= (i_item.mode == rbp_pkg::MODE_DRAIN) || (r_row != '0);
            r_s1_pix     <= pix;
            r_s1_left    <= col_sel == '0;
            r_s1_right   <= col_sel == r_wm1;
            r_s1_last    <= (i_item.mode == rbp_pkg::MODE_DRAIN) && second;
        end
    end

    assign o_cmd_push     = r_s1_valid;
    assign o_cmd.pixel    = r_s1_use_ram ? ram_q : r_s1_pix;
    assign o_cmd.left     = r_s1_left;
    assign o_cmd.right    = r_s1_right;
    assign o_cmd.last_out = r_s1_last;

endmodule

`default_nettype wire

[hw/rtl/rbp_cmd_queue.sv]
`default_nettype none

module rbp_cmd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire rbp_pkg::t_cmd   i_cmd,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output rbp_pkg::t_cmd        o_cmd,
    output rbp_pkg::t_qstat      o_stat
);
    localparam int DEPTH = rbp_pkg::CMDQ_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    rbp_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;
    logic          do_push, do_pop;

    assign do_push = i_push;
    assign do_pop  = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];
    // leave one slot for the item already in the front's read stage
    assign o_stat.afull = r_cnt >= (PW+1)'(DEPTH - 1);
    assign o_stat.full  = r_cnt == (PW+1)'(DEPTH);

endmodule

`default_nettype wire

[hw/rtl/rbp_back.sv]
`default_nettype none

module rbp_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire rbp_pkg::t_cmd       i_cmd,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output rbp_pkg::t_out_item       o_item,
    output logic                     o_cmd_pop
);
    logic [1:0] r_phase, n_phase;
    logic [1:0] last_idx;
    logic       is_last, is_right, take;

    // results per item: optional left pad, the pixel, optional right pad
    assign last_idx = 2'(i_cmd.left) + 2'(i_cmd.right) ;
    assign is_last  = r_phase == last_idx;
    assign is_right = i_cmd.right && is_last;
    assign take     = i_pop && i_valid;

    always_comb begin
        n_phase = r_phase;
        if (take) begin
            n_phase = is_last ? 2'd0 : r_phase + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else begin
            r_phase <= n_phase;
        end
    end

    assign o_empty            = !i_valid;
    assign o_item.pixel_out   = 8'(i_cmd.pixel);
    assign o_item.row_end     = is_right;
    assign o_item.frame_end   = is_right && i_cmd.last_out;
    assign o_item.last_of_run = is_last;
    assign o_cmd_pop          = take && is_last;

endmodule

`default_nettype wire

[hw/rtl/replicate_border_pad.sv]
`default_nettype none

// One-pixel replicate border padding of a grey raster stream. Pixels go in
// with mode 0 in raster order; after the frame, 2*W drain items (mode 1)
// flush the last row. Out comes the (W+2)x(H+2) frame, edges and corners
// copied from the nearest image pixel. The front side takes one item per
// cycle unless the queue is almost full, into a one-row line buffer (a
// single RAM, one read and one write per cycle); an item's first result is
// ready once it has passed the front's read stage and entered the queue.
// The back side sends one result per cycle while pop is high: one for an
// inner item, two for an edge item (three at width one), W+2 per row of W.
// A four-entry queue between the sides keeps input flowing while results
// wait. A register write restarts the frame; the line buffer keeps its data.
module replicate_border_pad #(
    parameter int MAX_WIDTH = rbp_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    input  wire rbp_pkg::t_in_item                   i_in_item,
    output logic                                     full,
    output logic                                     empty,
    input  wire logic                                pop,
    output rbp_pkg::t_out_item                       o_out_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [rbp_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [rbp_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    logic            cmd_push, cmd_pop, cmd_valid;
    rbp_pkg::t_cmd   cmd_in, cmd_head;
    rbp_pkg::t_qstat q_stat;

    rbp_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_in_item),
        .i_hold      (q_stat.afull),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    rbp_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_head),
        .o_stat  (q_stat)
    );

    rbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (cmd_valid),
        .i_cmd     (cmd_head),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item),
        .o_cmd_pop (cmd_pop)
    );

    assign full = q_stat.afull;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd_push && q_stat.full && !cmd_pop))
        else $error("command queue overflow");

    a_frame_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.frame_end) |-> o_out_item.row_end)
        else $error("frame_end without row_end");

    a_row_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.row_end) |-> o_out_item.last_of_run)
        else $error("row_end not on last result of its item");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("results pending after reset");
`endif

endmodule

`default_nettype wire
